@@ design/vsce_pkg.sv @@
// Package: shared constants, types and decay-table function for the value-scored cache directory.
`timescale 1ns / 1ps
package vsce_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int DECAY_DEPTH_DEF = 1024;
    localparam logic [39:0] BUDGET_RESET = 40'd1073741824;
    localparam logic [63:0] DECAY_K = 64'd4223977731;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_HIT      = 3'd2;
    localparam logic [2:0] ST_MISS     = 3'd3;
    localparam logic [2:0] ST_TICK     = 3'd4;
    localparam logic [2:0] ST_REJECT   = 3'd5;

    typedef struct packed {
        logic scan_start;
        logic find_start;
        logic evict;
        logic do_insert;
        logic do_hit;
        logic do_miss;
        logic do_tick;
        logic do_present;
        logic do_reject;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic found;
        logic oversize;
        logic need_evict;
    } t_sts;

    function automatic logic [15:0] recency_at(input int age);
        logic [63:0] t;
        logic [63:0] r;
        t = 64'd1 << 32;
        for (int a = 1; a <= age; a++) begin
            t = (t * DECAY_K + (64'd1 << 31)) >> 32;
        end
        r = (t + 64'd32768) >> 16;
        if (r > 64'd65535) begin
            r = 64'd65535;
        end
        return r[15:0];
    endfunction
endpackage

@@ design/value_scored_cache_eviction.sv @@
// Top level: value-scored cache directory with byte budget.
// channel | direction | content
// s_axis  | in        | tdata: op, entry_id, entry_bytes, prio_level, is_prefetch_fill
// m_axis  | out       | tdata: status, slot_index, evicted_count, five totals, bytes_in_use
// cfg     | in        | byte_budget write
// A get or an insert without eviction goes from accept to the result register after a
// lookup that walks one slot a cycle; a tick goes straight to the result stage.
// Each eviction adds a slot walk, a table read, two score stages and the evict.
// Reset is synchronous; the directory is empty after reset, no clearing pass.
// One item at a time; a finished item waits until the result register is free.
`timescale 1ns / 1ps
module value_scored_cache_eviction
    import vsce_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int DECAY_TABLE_DEPTH = DECAY_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], entry_id[33:2], entry_bytes[73:34], prio_level[75:74], is_prefetch_fill[76]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], slot_index[6:3], evicted_count[11:7], hit_total[43:12],
    // miss_total[75:44], prefetched_total[107:76], useful_prefetch_total[139:108],
    // wasted_prefetch_total[171:140], bytes_in_use[211:172]
    output logic [215:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [39:0]  i_cfg_wdata
);
    t_cmd c_cmd;
    t_sts c_sts;
    logic c_idle, c_load, c_fire;
    logic r_mvalid;
    logic [215:0] r_mdata;
    logic [2:0] c_status;
    logic [3:0] c_slot;
    logic [4:0] c_evc;
    logic [4:0][31:0] c_stat;
    logic [39:0] c_used;

    assign s_axis_tready = c_idle;
    assign c_fire = s_axis_tvalid && s_axis_tready;

    vsce_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(c_fire),
        .i_op(s_axis_tdata[1:0]), .i_sts(c_sts),
        .i_out_free(!r_mvalid || m_axis_tready),
        .o_cmd(c_cmd), .o_idle(c_idle), .o_out_load(c_load)
    );

    vsce_dp #(.SLOTS(SLOTS), .DECAY_TABLE_DEPTH(DECAY_TABLE_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(c_cmd), .i_in_load(c_fire),
        .i_id(s_axis_tdata[33:2]), .i_bytes(s_axis_tdata[73:34]),
        .i_prio(s_axis_tdata[75:74]), .i_pf(s_axis_tdata[76]),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_wdata),
        .o_sts(c_sts), .o_status(c_status), .o_slot(c_slot), .o_evicted(c_evc),
        .o_stat(c_stat), .o_used(c_used)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (c_load) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_mdata <= {4'd0, c_used, c_stat[4], c_stat[3], c_stat[2], c_stat[1],
                        c_stat[0], c_evc, c_slot, c_status};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata = r_mdata;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_load |-> !c_fire) else $error("accept while result pending");
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_load |-> (!r_mvalid || m_axis_tready)) else $error("result overwritten");
    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_load |=> m_axis_tvalid) else $error("lost result");
endmodule

@@ design/vsce_ctrl.sv @@
// Controller: sequences lookup, eviction scans and updates for each item.
`timescale 1ns / 1ps
module vsce_ctrl
    import vsce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_fire,
    input  logic [1:0] i_op,
    input  t_sts       i_sts,
    input  logic       i_out_free,
    output t_cmd       o_cmd,
    output logic       o_idle,
    output logic       o_out_load
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_EVWT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_INSERT;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        o_cmd = '0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    n_op = i_op;
                    if (i_op == OP_TICK) begin
                        o_cmd.do_tick = 1'b1;
                        n_state = S_OUT;
                    end else if (i_op != OP_UNUSED) begin
                        o_cmd.find_start = 1'b1;
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (!i_sts.busy) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_op == OP_GET) begin
                    o_cmd.do_hit = i_sts.found;
                    o_cmd.do_miss = !i_sts.found;
                    n_state = S_OUT;
                end else if (i_sts.found) begin
                    o_cmd.do_present = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.oversize) begin
                    o_cmd.do_reject = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.need_evict) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.do_insert = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                if (!i_sts.busy) begin
                    o_cmd.evict = 1'b1;
                    n_state = S_EVWT;
                end
            end
            S_EVWT: n_state = S_DEC;
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.do_insert, o_cmd.do_hit, o_cmd.do_miss, o_cmd.do_tick,
                  o_cmd.evict, o_cmd.do_present, o_cmd.do_reject}))
        else $error("multiple commands");
    a_evict_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.evict |-> r_state == S_SCAN) else $error("evict outside scan");
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |=> r_state == S_IDLE) else $error("load without idle");
endmodule

@@ design/vsce_dp.sv @@
// Datapath: slot store, serial lookup and score scan, statistics.
`timescale 1ns / 1ps
module vsce_dp
    import vsce_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int DECAY_TABLE_DEPTH = DECAY_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_in_load,
    input  logic [31:0]      i_id,
    input  logic [39:0]      i_bytes,
    input  logic [1:0]       i_prio,
    input  logic             i_pf,
    input  logic             i_cfg_we,
    input  logic [39:0]      i_cfg_data,
    output t_sts             o_sts,
    output logic [2:0]       o_status,
    output logic [3:0]       o_slot,
    output logic [4:0]       o_evicted,
    output logic [4:0][31:0] o_stat,
    output logic [39:0]      o_used
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(DECAY_TABLE_DEPTH);

    logic [15:0] c_rom [DECAY_TABLE_DEPTH];
    always_comb begin
        for (int a = 0; a < DECAY_TABLE_DEPTH; a++) begin
            c_rom[a] = recency_at(a);
        end
    end

    logic [SLOTS-1:0] r_valid;
    logic [31:0] r_sid [SLOTS];
    logic [39:0] r_sbytes [SLOTS];
    logic [31:0] r_seen [SLOTS];
    logic [SLOTS-1:0] r_spf, r_sused;
    logic [1:0] r_sprio [SLOTS];
    logic [31:0] r_shits [SLOTS];

    logic [39:0] r_budget, r_used;
    logic [31:0] r_now;
    logic [31:0] r_stat [5];
    logic [31:0] r_id;
    logic [39:0] r_bytes;
    logic [1:0] r_prio;
    logic r_pf;

    logic r_busy, r_mode_scan;
    logic [CW-1:0] r_ptr;
    logic r_found;
    logic [SW-1:0] r_fslot;
    logic r_have;
    logic [SW-1:0] r_best;
    logic [63:0] r_bestv;
    // score pipeline
    logic r_p0v;
    logic [SW-1:0] r_p0s;
    logic [15:0] r_p0rec;
    logic r_p0ok;
    logic [4:0] r_p0pu;
    logic [1:0] r_p0pr;
    logic [31:0] r_p0h;
    logic r_p1v;
    logic [SW-1:0] r_p1s;
    logic [31:0] r_p1a;
    logic [31:0] r_p1h;
    logic r_p2v;
    logic [SW-1:0] r_p2s;
    logic [63:0] r_p2v64;
    logic [4:0] r_evc;
    logic [2:0] r_status;
    logic [SW-1:0] r_slot;

    logic [SW-1:0] c_idx, c_free;
    logic c_anyfree;
    logic [31:0] c_age;
    logic [15:0] c_rec;
    logic [4:0] c_pu;
    logic [31:0] c_mix;

    assign c_idx = r_ptr[SW-1:0];
    assign c_age = r_now - r_seen[c_idx];
    always_comb begin
        logic [3:0] p;
        logic [3:0] u;
        p = r_spf[c_idx] ? 4'd5 : 4'd10;
        u = r_sused[c_idx] ? 4'd10 : 4'd2;
        c_pu = 5'((8'(p) * 8'(u)) >> 1);
    end
    assign c_rec = r_p0ok ? r_p0rec : 16'd0;
    assign c_mix = 32'(c_rec) * 32'(r_p0pu) * 32'({1'b0, r_p0pr} + 3'd1) * 32'd2;

    always_comb begin
        c_free = '0;
        c_anyfree = 1'b0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                c_free = SW'(s);
                c_anyfree = 1'b1;
            end
        end
    end

    logic [40:0] c_sum;
    assign c_sum = {1'b0, r_used} + {1'b0, r_bytes};

    assign o_sts.busy = r_busy;
    assign o_sts.found = r_found;
    assign o_sts.oversize = r_bytes > r_budget;
    assign o_sts.need_evict = (c_sum > {1'b0, r_budget}) || !c_anyfree;

    always_ff @(posedge i_clk) begin
        if (i_in_load) begin
            r_id <= i_id;
            r_bytes <= i_bytes;
            r_prio <= i_prio;
            r_pf <= i_pf;
        end
        r_p0s <= c_idx;
        r_p0rec <= c_rom[c_age[AW-1:0]];
        r_p0ok <= c_age < 32'(DECAY_TABLE_DEPTH);
        r_p0pu <= c_pu;
        r_p0pr <= r_sprio[c_idx];
        r_p0h <= r_shits[c_idx];
        r_p1s <= r_p0s;
        r_p1a <= c_mix;
        r_p1h <= r_p0h;
        r_p2s <= r_p1s;
        r_p2v64 <= 64'(r_p1a) * 64'(r_p1h);
        if (i_cmd.do_insert) begin
            r_sid[c_free] <= r_id;
            r_sbytes[c_free] <= r_bytes;
            r_seen[c_free] <= r_now;
            r_spf[c_free] <= r_pf;
            r_sused[c_free] <= 1'b0;
            r_sprio[c_free] <= r_prio;
            r_shits[c_free] <= '0;
        end
        if (i_cmd.do_hit) begin
            r_seen[r_fslot] <= r_now;
            if (r_shits[r_fslot] != '1) begin
                r_shits[r_fslot] <= r_shits[r_fslot] + 32'd1;
            end
            r_sused[r_fslot] <= r_sused[r_fslot] | r_spf[r_fslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_budget <= BUDGET_RESET;
            r_used <= '0;
            r_now <= '0;
            for (int k = 0; k < 5; k++) begin
                r_stat[k] <= '0;
            end
            r_busy <= 1'b0;
            r_mode_scan <= 1'b0;
            r_ptr <= '0;
            r_found <= 1'b0;
            r_fslot <= '0;
            r_have <= 1'b0;
            r_best <= '0;
            r_bestv <= '0;
            r_p0v <= 1'b0;
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
            r_evc <= '0;
            r_status <= ST_TICK;
            r_slot <= '0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_data;
            end
            r_p0v <= 1'b0;
            r_p1v <= r_p0v;
            r_p2v <= r_p1v;
            if (i_cmd.find_start) begin
                r_busy <= 1'b1;
                r_mode_scan <= 1'b0;
                r_ptr <= '0;
                r_found <= 1'b0;
                r_evc <= '0;
                r_slot <= '0;
            end else if (i_cmd.scan_start) begin
                r_busy <= 1'b1;
                r_mode_scan <= 1'b1;
                r_ptr <= '0;
                r_have <= 1'b0;
            end else if (r_busy && !r_mode_scan) begin
                if (r_valid[c_idx] && r_sid[c_idx] == r_id) begin
                    r_found <= 1'b1;
                    r_fslot <= c_idx;
                    r_busy <= 1'b0;
                end else if (r_ptr == CW'(SLOTS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_ptr <= r_ptr + 1'b1;
            end else if (r_busy) begin
                if (r_ptr < CW'(SLOTS)) begin
                    r_p0v <= r_valid[c_idx];
                    r_ptr <= r_ptr + 1'b1;
                end else if (!r_p0v && !r_p1v && !r_p2v) begin
                    r_busy <= 1'b0;
                end
            end
            if (r_p2v && (!r_have || r_p2v64 < r_bestv)) begin
                r_have <= 1'b1;
                r_best <= r_p2s;
                r_bestv <= r_p2v64;
            end
            if (i_cmd.evict && r_have) begin
                r_valid[r_best] <= 1'b0;
                r_used <= r_used - r_sbytes[r_best];
                if (r_spf[r_best] && !r_sused[r_best]) begin
                    r_stat[4] <= r_stat[4] + 32'd1;
                end
            end
            if (i_cmd.evict) begin
                r_evc <= r_evc + 5'd1;
            end
            if (i_cmd.do_insert) begin
                r_valid[c_free] <= 1'b1;
                r_used <= c_sum[39:0];
                if (r_pf) begin
                    r_stat[2] <= r_stat[2] + 32'd1;
                end
                r_status <= ST_INSERTED;
                r_slot <= c_free;
            end
            if (i_cmd.do_hit) begin
                r_stat[0] <= r_stat[0] + 32'd1;
                if (r_spf[r_fslot] && !r_sused[r_fslot]) begin
                    r_stat[3] <= r_stat[3] + 32'd1;
                end
                r_status <= ST_HIT;
                r_slot <= r_fslot;
            end
            if (i_cmd.do_miss) begin
                r_stat[1] <= r_stat[1] + 32'd1;
                r_status <= ST_MISS;
            end
            if (i_cmd.do_present) begin
                r_status <= ST_PRESENT;
                r_slot <= r_fslot;
            end
            if (i_cmd.do_reject) begin
                r_status <= ST_REJECT;
            end
            if (i_cmd.do_tick) begin
                r_now <= r_now + 32'd1;
                r_status <= ST_TICK;
                r_slot <= '0;
                r_evc <= '0;
            end
        end
    end

    assign o_status = r_status;
    assign o_slot = 4'(r_slot);
    assign o_evicted = (r_status == ST_INSERTED) ? r_evc : 5'd0;
    assign o_stat = {r_stat[4], r_stat[3], r_stat[2], r_stat[1], r_stat[0]};
    assign o_used = r_used;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_insert |-> !o_sts.need_evict) else $error("insert without room");
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |-> !r_busy) else $error("evict during scan");
    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_hit |-> r_found) else $error("hit without match");
endmodule
